>>> design/btls_pkg.sv
// Shared types and constants for the blinking traffic light sequencer.
`default_nettype none

package btls_pkg;

    localparam int TIMER_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PHASE_W = 2;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // Register reset values
    localparam logic [TIMER_W-1:0] RED_DURATION_RST        = 16'd5000;
    localparam logic [TIMER_W-1:0] GREEN_DURATION_RST      = 16'd4000;
    localparam logic [TIMER_W-1:0] YELLOW_DURATION_RST     = 16'd2000;
    localparam logic [TIMER_W-1:0] RED_BLINK_PERIOD_RST    = 16'd500;
    localparam logic [TIMER_W-1:0] GREEN_BLINK_PERIOD_RST  = 16'd300;
    localparam logic [TIMER_W-1:0] YELLOW_BLINK_PERIOD_RST = 16'd200;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RED_DURATION        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_DURATION      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW_DURATION     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_BLINK_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_BLINK_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW_BLINK_PERIOD = 3'd5;

    // Encoded phase as seen on the result port
    localparam logic [PHASE_W-1:0] PHASE_CODE_RED    = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_GREEN  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_YELLOW = 2'd2;

    typedef enum logic [2:0] {
        PH_RED    = 3'b001,
        PH_GREEN  = 3'b010,
        PH_YELLOW = 3'b100
    } phase_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_GREEN:  code = PHASE_CODE_GREEN;
            PH_YELLOW: code = PHASE_CODE_YELLOW;
            default:   code = PHASE_CODE_RED;
        endcase
        return code;
    endfunction

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
        return (v == TIMER_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

>>> design/blinking_traffic_light_sequencer_top.sv
// Three-phase blinking traffic light sequencer, one tick word in, one lamp word out.
// An accepted tick word's result word is registered and shows on the m_ side the cycle after.
// Throughput: one word per cycle while m_ready drains the output; timers move on s_advance.
// s_ready stays high while the output register is empty or being drained.
// Reset (aresetn low, synchronous): red phase, timers at zero, lamp lit,
// registers back to their defaults and no result pending.
`default_nettype none

module blinking_traffic_light_sequencer_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [btls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [btls_pkg::TIMER_W-1:0]    cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_advance,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_red_lamp,
    output logic                                 m_yellow_lamp,
    output logic                                 m_green_lamp,
    output logic [btls_pkg::PHASE_W-1:0]         m_phase,
    output logic                                 m_phase_changed
);
    import btls_pkg::*;

    logic [TIMER_W-1:0] red_duration_reg, green_duration_reg, yellow_duration_reg;
    logic [TIMER_W-1:0] red_period_reg, green_period_reg, yellow_period_reg;

    phase_t             phase_reg, phase_next;
    logic [TIMER_W-1:0] phase_elapsed_reg, phase_elapsed_next;
    logic [TIMER_W-1:0] blink_elapsed_reg, blink_elapsed_next;
    logic               lamp_on_reg, lamp_on_next;
    logic               changed_next;

    logic               m_valid_reg;
    logic               red_lamp_reg, yellow_lamp_reg, green_lamp_reg;
    logic [PHASE_W-1:0] phase_out_reg;
    logic               changed_reg;

    logic               s_accept;
    logic [TIMER_W-1:0] cur_duration, cur_period;
    logic [TIMER_W-1:0] phase_inc, blink_inc;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_duration_reg    <= RED_DURATION_RST;
            green_duration_reg  <= GREEN_DURATION_RST;
            yellow_duration_reg <= YELLOW_DURATION_RST;
            red_period_reg      <= RED_BLINK_PERIOD_RST;
            green_period_reg    <= GREEN_BLINK_PERIOD_RST;
            yellow_period_reg   <= YELLOW_BLINK_PERIOD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_RED_DURATION:        red_duration_reg    <= cfg_wdata;
                REG_GREEN_DURATION:      green_duration_reg  <= cfg_wdata;
                REG_YELLOW_DURATION:     yellow_duration_reg <= cfg_wdata;
                REG_RED_BLINK_PERIOD:    red_period_reg      <= cfg_wdata;
                REG_GREEN_BLINK_PERIOD:  green_period_reg    <= cfg_wdata;
                REG_YELLOW_BLINK_PERIOD: yellow_period_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (phase_reg)
            PH_GREEN: begin
                cur_duration = green_duration_reg;
                cur_period   = green_period_reg;
            end
            PH_YELLOW: begin
                cur_duration = yellow_duration_reg;
                cur_period   = yellow_period_reg;
            end
            default: begin
                cur_duration = red_duration_reg;
                cur_period   = red_period_reg;
            end
        endcase
    end

    assign phase_inc = sat_inc(phase_elapsed_reg);
    assign blink_inc = sat_inc(blink_elapsed_reg);

    always_comb begin
        phase_next         = phase_reg;
        phase_elapsed_next = phase_elapsed_reg;
        blink_elapsed_next = blink_elapsed_reg;
        lamp_on_next       = lamp_on_reg;
        changed_next       = 1'b0;
        if (s_advance) begin
            phase_elapsed_next = phase_inc;
            blink_elapsed_next = blink_inc;
            if (blink_inc >= cur_period) begin
                blink_elapsed_next = '0;
                lamp_on_next       = !lamp_on_reg;
            end
            // blink timer deliberately carries over the phase change
            if (phase_inc >= cur_duration) begin
                phase_elapsed_next = '0;
                lamp_on_next       = 1'b1;
                changed_next       = 1'b1;
                unique case (phase_reg)
                    PH_GREEN:  phase_next = PH_YELLOW;
                    PH_YELLOW: phase_next = PH_RED;
                    default:   phase_next = PH_GREEN;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_RED;
            phase_elapsed_reg <= '0;
            blink_elapsed_reg <= '0;
            lamp_on_reg       <= 1'b1;
        end else if (s_accept) begin
            phase_reg         <= phase_next;
            phase_elapsed_reg <= phase_elapsed_next;
            blink_elapsed_reg <= blink_elapsed_next;
            lamp_on_reg       <= lamp_on_next;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            red_lamp_reg    <= (phase_next == PH_RED)    && lamp_on_next;
            yellow_lamp_reg <= (phase_next == PH_YELLOW) && lamp_on_next;
            green_lamp_reg  <= (phase_next == PH_GREEN)  && lamp_on_next;
            phase_out_reg   <= phase_code(phase_next);
            changed_reg     <= changed_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_red_lamp      = red_lamp_reg;
    assign m_yellow_lamp   = yellow_lamp_reg;
    assign m_green_lamp    = green_lamp_reg;
    assign m_phase         = phase_out_reg;
    assign m_phase_changed = changed_reg;

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with an empty output register");

    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("phase register not one-hot");

    a_hold_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_advance |=> m_valid && !m_phase_changed)
        else $error("phase changed on a hold word");

    a_single_lamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_red_lamp, m_yellow_lamp, m_green_lamp}))
        else $error("more than one lamp lit");

endmodule

`default_nettype wire
